[src/bmpru_pkg.sv]
// shared types and constants for the bitmap row pixel unpacker
package bmpru_pkg;

  localparam int unsigned MAX_WIDTH_DEF       = 4096;
  localparam int unsigned PALETTE_ENTRIES_DEF = 256;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH  = 2'd1;

  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_PIXEL   = 1'b1;

  typedef enum logic [2:0] {
    DEPTH_1  = 3'd0,
    DEPTH_4  = 3'd1,
    DEPTH_8  = 3'd2,
    DEPTH_16 = 3'd3,
    DEPTH_24 = 3'd4,
    DEPTH_32 = 3'd5
  } depth_e;

  // how a queued byte turns into pixels
  typedef enum logic [1:0] {
    JOB_BIT1   = 2'd0,
    JOB_NIBBLE = 2'd1,
    JOB_BYTE   = 2'd2,
    JOB_DIRECT = 2'd3
  } job_kind_e;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
    logic [7:0]  data_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] pixel_column;
    logic        row_end;
    logic        last_of_item;
  } out_word_t;

endpackage

[src/bmp_row_pixel_unpacker.sv]
// bitmap row pixel unpacker: byte accept, palette memory read, output register
// a byte's first pixel passes the job register, the palette read stage and the output register
// throughput: one byte per cycle at 8/16/24/32 bits while the output is not stalled; at 1 and 4
//   bits a byte yields up to 8 or 2 pixels, issued one per cycle, set by the single palette read port
// reset: row counters cleared, depth 8 bits, width 1; palette contents undefined
module bmp_row_pixel_unpacker #(
  parameter int unsigned MAX_WIDTH       = bmpru_pkg::MAX_WIDTH_DEF,
  parameter int unsigned PALETTE_ENTRIES = bmpru_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bmpru_pkg::in_word_t            in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bmpru_pkg::out_word_t           out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bmpru_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bmpru_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bmpru_pkg::*;

  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned BW = CW + 3;
  localparam int unsigned PW = $clog2(PALETTE_ENTRIES);

  typedef struct packed {
    job_kind_e     kind;
    logic [23:0]   color;
    logic [3:0]    cnt;
    logic [2:0]    sel;
    logic [CW-1:0] col;
  } job_t;

  typedef struct packed {
    logic          use_pal;
    logic          pal_zero;
    logic [23:0]   color;
    logic [CW-1:0] col;
    logic          row_end;
    logic          last;
  } pix_t;

  // configuration and row state
  depth_e          depth_q;
  logic [12:0]     width_q;
  logic [BW-1:0]   pos_q, pos_d;
  logic [CW-1:0]   col_q, col_d;
  logic [15:0]     pp_q, pp_d;
  logic [1:0]      pbc_q, pbc_d;

  logic            job_valid_q, job_valid_d;
  job_t            job_q, job_d;
  logic            s1_valid_q;
  pix_t            s1_q;
  logic [23:0]     pal_rd_q;
  logic            out_valid_q;
  out_word_t       out_q;

  logic [23:0]     pal_mem [PALETTE_ENTRIES];

  logic            cfg_hit;
  logic            s2_free, s1_free, issue, job_done, in_acc, pal_we;
  logic [CW-1:0]   w_eff, w_rem;
  logic [BW-1:0]   data_len, row_len, pos_inc;
  logic            in_data;
  logic [3:0]      n_pix;
  job_kind_e       new_kind;
  logic [23:0]     new_color;
  logic [7:0]      rd_idx;
  logic            rd_oob, wr_oob;
  logic [8:0]      pal_limit;
  logic [7:0]      b;

  assign pal_limit = 9'(PALETTE_ENTRIES);
  assign cfg_hit   = cfg_we_i && (cfg_index_i == CFG_DEPTH_MODE || cfg_index_i == CFG_ROW_WIDTH);
  assign s2_free   = !out_valid_q || out_ready_i;
  assign s1_free   = !s1_valid_q || s2_free;
  assign issue     = job_valid_q && s1_free;
  assign job_done  = issue && (job_q.cnt == 4'd1);
  assign in_ready_o = !job_valid_q || job_done;
  assign in_acc    = in_valid_i && in_ready_o;
  assign wr_oob    = {1'b0, in_data_i.palette_index} >= pal_limit;
  assign pal_we    = in_acc && (in_data_i.opcode == OP_PALETTE) && !wr_oob;
  assign b         = in_data_i.data_byte;

  // effective width and row geometry
  always_comb begin
    if (width_q == 13'd0) begin
      w_eff = CW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_q);
    end
    case (depth_q)
      DEPTH_1:  data_len = BW'((BW'(w_eff) + BW'(7)) >> 3);
      DEPTH_4:  data_len = BW'((BW'(w_eff) + BW'(1)) >> 1);
      DEPTH_16: data_len = BW'(w_eff) << 1;
      DEPTH_24: data_len = (BW'(w_eff) << 1) + BW'(w_eff);
      DEPTH_32: data_len = BW'(w_eff) << 2;
      default:  data_len = BW'(w_eff);
    endcase
    row_len = (data_len + BW'(3)) & ~BW'(3);
    in_data = pos_q < data_len;
    pos_inc = pos_q + BW'(1);
    w_rem   = (col_q < w_eff) ? (w_eff - col_q) : '0;
  end

  // byte accept: row counters and the new pixel job
  always_comb begin
    pos_d       = pos_q;
    col_d       = col_q;
    pp_d        = pp_q;
    pbc_d       = pbc_q;
    job_d       = job_q;
    job_valid_d = job_valid_q;
    n_pix       = 4'd0;
    new_kind    = JOB_BYTE;
    new_color   = {16'd0, b};

    if (issue) begin
      job_d.cnt = job_q.cnt - 4'd1;
      job_d.sel = job_q.sel + 3'd1;
      job_d.col = job_q.col + CW'(1);
      if (job_done) begin
        job_valid_d = 1'b0;
      end
    end

    if (cfg_hit) begin
      pos_d = '0;
      col_d = '0;
      pp_d  = '0;
      pbc_d = '0;
    end else if (in_acc && in_data_i.opcode == OP_PIXEL) begin
      if (in_data) begin
        case (depth_q)
          DEPTH_1: begin
            new_kind = JOB_BIT1;
            n_pix    = (w_rem >= CW'(8)) ? 4'd8 : w_rem[3:0];
          end
          DEPTH_4: begin
            new_kind = JOB_NIBBLE;
            n_pix    = (w_rem >= CW'(2)) ? 4'd2 : w_rem[3:0];
          end
          DEPTH_16: begin
            new_kind = JOB_DIRECT;
            if (pbc_q == 2'd0) begin
              pp_d  = {8'd0, b};
              pbc_d = 2'd1;
            end else begin
              n_pix     = 4'd1;
              new_color = {b[6:2], 3'd0, b[1:0], pp_q[7:5], 3'd0, pp_q[4:0], 3'd0};
              pp_d      = '0;
              pbc_d     = 2'd0;
            end
          end
          DEPTH_24, DEPTH_32: begin
            new_kind = JOB_DIRECT;
            if (pbc_q == 2'd0) begin
              pp_d  = {8'd0, b};
              pbc_d = 2'd1;
            end else if (pbc_q == 2'd1) begin
              pp_d  = {b, pp_q[7:0]};
              pbc_d = 2'd2;
            end else if (pbc_q == 2'd2) begin
              n_pix     = 4'd1;
              new_color = {b, pp_q};
              pp_d      = '0;
              pbc_d     = (depth_q == DEPTH_32) ? 2'd3 : 2'd0;
            end else begin
              pbc_d = 2'd0;
            end
          end
          default: begin
            new_kind = JOB_BYTE;
            n_pix    = 4'd1;
          end
        endcase
      end
      col_d = col_q + CW'(n_pix);
      pos_d = pos_inc;
      if (pos_inc >= row_len) begin
        pos_d = '0;
        col_d = '0;
        pp_d  = '0;
        pbc_d = '0;
      end
      if (n_pix != 4'd0) begin
        job_valid_d = 1'b1;
        job_d.kind  = new_kind;
        job_d.color = new_color;
        job_d.cnt   = n_pix;
        job_d.sel   = 3'd0;
        job_d.col   = col_q;
      end
    end
  end

  // palette index of the pixel being issued
  always_comb begin
    case (job_q.kind)
      JOB_BIT1:   rd_idx = {7'd0, job_q.color[3'd7 - job_q.sel]};
      JOB_NIBBLE: rd_idx = (job_q.sel == 3'd0) ? {4'd0, job_q.color[7:4]}
                                               : {4'd0, job_q.color[3:0]};
      default:    rd_idx = job_q.color[7:0];
    endcase
    rd_oob = {1'b0, rd_idx} >= pal_limit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q     <= DEPTH_8;
      width_q     <= 13'd1;
      pos_q       <= '0;
      col_q       <= '0;
      pp_q        <= '0;
      pbc_q       <= '0;
      job_valid_q <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_DEPTH_MODE) begin
        depth_q <= depth_e'(cfg_data_i[2:0]);
      end
      if (cfg_we_i && cfg_index_i == CFG_ROW_WIDTH) begin
        width_q <= cfg_data_i[12:0];
      end
      pos_q       <= pos_d;
      col_q       <= col_d;
      pp_q        <= pp_d;
      pbc_q       <= pbc_d;
      job_valid_q <= job_valid_d;
      if (s1_free) begin
        s1_valid_q <= issue;
      end
      if (s2_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    if (issue) begin
      s1_q.use_pal  <= (job_q.kind != JOB_DIRECT);
      s1_q.pal_zero <= rd_oob;
      s1_q.color    <= job_q.color;
      s1_q.col      <= job_q.col;
      s1_q.row_end  <= (job_q.col + CW'(1)) == w_eff;
      s1_q.last     <= (job_q.cnt == 4'd1);
    end
    if (s2_free && s1_valid_q) begin
      if (s1_q.use_pal) begin
        {out_q.red, out_q.green, out_q.blue} <= s1_q.pal_zero ? 24'd0 : pal_rd_q;
      end else begin
        {out_q.red, out_q.green, out_q.blue} <= s1_q.color;
      end
      out_q.pixel_column <= 12'(s1_q.col);
      out_q.row_end      <= s1_q.row_end;
      out_q.last_of_item <= s1_q.last;
    end
  end

  // palette memory: read before write on the same entry
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[in_data_i.palette_index[PW-1:0]] <= in_data_i.palette_color;
    end
    if (issue) begin
      pal_rd_q <= pal_mem[rd_idx[PW-1:0]];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
